// ----- hw/rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared field widths, operation codes and status codes for the deque core.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_DUMP       = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ----- hw/rtl/dq_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cmd_if
// Command channel: one operation and its push word per handshake.
// ----------------------------------------------------------------------------
interface dq_cmd_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ----- hw/rtl/dq_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_res_if
// Result channel: moved word, status, end-of-run flag and entry count.
// ----------------------------------------------------------------------------
interface dq_res_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_res;
  logic [STATUS_W-1:0]       status;
  logic                      last;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, output value_res, output status, output last,
                  output count, input ready);
  modport sink   (input valid, input value_res, input status, input last,
                  input count, output ready);
endinterface

// ----- hw/rtl/double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque of signed 32-bit words held in a ring buffer RAM.
//
// Channels: cmd carries one operation (push front/back, pop front/back,
// clear, dump) with its push word; res returns value_res, status, last and
// the entry count. A word is moved when valid and ready are both high.
// Push, clear, and any refused push or empty pop: result registered in the
// cycle after the command, one command per cycle when res is not stalled.
// Pop: waits in S_POP_WAIT for the registered RAM read, taking no new command.
// Dump: one word per held entry, front to back, last set on the
// back entry; an empty dump gives one word with status empty.
// Codes 6 and 7 are taken and dropped without a result.
// Reset empties the queue (front index and count cleared); RAM contents are
// not cleared and no clearing pass is run.
// res is driven from an output register; a stall on res holds that word and
// stalls cmd until it drains, as cmd is taken only when the register frees.
// ----------------------------------------------------------------------------
module double_ended_queue_core import dq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  dq_cmd_if.sink   cmd,
  dq_res_if.source res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_DUMP_WAIT
  } state_t;

  state_t               state, state_next;
  logic [IDX_W-1:0]     front, front_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     dump_cursor, dump_cursor_next;
  logic [IDX_W-1:0]     addr, addr_next;

  logic                 res_valid;
  logic [VALUE_W-1:0]   res_value;
  status_t              res_status;
  logic                 res_last;
  logic [CNT_W-1:0]     res_count;

  logic                 load;
  logic [VALUE_W-1:0]   load_value;
  status_t              load_status;
  logic                 load_last;
  logic [CNT_W-1:0]     load_count;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [VALUE_W-1:0]   rdata;

  logic                 out_free;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 dump_last;

  // front + offset, wrapped into the ring; offset is at most DEPTH
  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  dq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (addr_next),
    .rdata (rdata)
  );

  assign out_free  = !res_valid || res.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign dump_last = ((dump_cursor + CNT_W'(1)) == count);

  always_comb begin
    state_next       = state;
    front_next       = front;
    count_next       = count;
    dump_cursor_next = dump_cursor;
    addr_next        = addr;
    we               = 1'b0;
    waddr            = ring_slot(front, count);
    load             = 1'b0;
    load_value       = '0;
    load_status      = ST_DONE;
    load_last        = 1'b1;
    load_count       = count;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              load = 1'b1;
              if (full) begin
                load_status = ST_FULL;
              end else begin
                we = 1'b1;
                if (cmd.operation == OP_PUSH_FRONT) begin
                  front_next = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
                  waddr      = front_next;
                end
                count_next = count + CNT_W'(1);
                load_value = cmd.value;
                load_count = count_next;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                load        = 1'b1;
                load_status = ST_EMPTY;
              end else begin
                if (cmd.operation == OP_POP_FRONT) begin
                  addr_next  = front;
                  front_next = ring_slot(front, CNT_W'(1));
                end else begin
                  addr_next = ring_slot(front, count - CNT_W'(1));
                end
                count_next = count - CNT_W'(1);
                state_next = S_POP_WAIT;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
              load       = 1'b1;
              load_count = '0;
            end
            OP_DUMP: begin
              dump_cursor_next = '0;
              if (empty) begin
                load        = 1'b1;
                load_status = ST_EMPTY;
              end else begin
                addr_next  = front;
                state_next = S_DUMP_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = rdata;
          state_next = S_IDLE;
        end
      end
      S_DUMP_WAIT: begin
        // next address is presented in the load cycle so data lands next cycle
        if (out_free) begin
          load             = 1'b1;
          load_value       = rdata;
          load_last        = dump_last;
          dump_cursor_next = dump_cursor + CNT_W'(1);
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            addr_next = (addr == IDX_W'(DEPTH - 1)) ? '0 : addr + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front       <= '0;
      count       <= '0;
      dump_cursor <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front       <= front_next;
      count       <= count_next;
      dump_cursor <= dump_cursor_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
    addr <= addr_next;
    if (load) begin
      res_value  <= load_value;
      res_status <= load_status;
      res_last   <= load_last;
      res_count  <= load_count;
    end
  end

  assign res.valid     = res_valid;
  assign res.value_res = res_value;
  assign res.status    = res_status;
  assign res.last      = res_last;
  assign res.count     = COUNT_W'(res_count);

endmodule

// ----- hw/rtl/dq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
